@@ design/compacting_keyed_record_table_unit_defines.svh @@
// ----------------------------------------------------------------------------
// compacting keyed record table: assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef COMPACTING_KEYED_RECORD_TABLE_UNIT_DEFINES_SVH
`define COMPACTING_KEYED_RECORD_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define CKRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CKRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ckrt_pkg.sv @@
// ----------------------------------------------------------------------------
// ckrt_pkg
// types, codes and defaults shared by the record table modules
// ----------------------------------------------------------------------------
package ckrt_pkg;

    localparam int DEF_MAX_RECORDS = 16;
    localparam int DEF_CHUNK_SIZE  = 4;
    localparam int DEF_NAME_BYTES  = 8;

    localparam int OP_W      = 2;
    localparam int KEY_W     = 32;
    localparam int PAY_W     = 64;
    localparam int IDX_IN_W  = 4;
    localparam int CNT_OUT_W = 5;
    localparam int ST_W      = 2;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd3;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_IDX,
        RD_PTR,
        RD_PTR1,
        RD_PTR2
    } rd_sel_t;

    typedef struct packed {
        logic            capture;
        logic            add_exec;
        rd_sel_t         rd_sel;
        logic            read_take;
        logic            ptr_inc;
        logic            wr_shift;
        logic            remove_commit;
        logic            set_status;
        logic [ST_W-1:0] status_code;
        logic            load_out;
    } ckrt_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            count_zero;
        logic            idx_ok;
        logic            key_match;
        logic            ptr_last;
        logic            ptr_next_last;
    } ckrt_sts_t;

endpackage

@@ design/ckrt_ram.sv @@
// ----------------------------------------------------------------------------
// ckrt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ckrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/ckrt_datapath.sv @@
// ----------------------------------------------------------------------------
// ckrt_datapath
// request registers, count and capacity, record memory and result register
// ----------------------------------------------------------------------------
module ckrt_datapath
    import ckrt_pkg::*;
#(
    parameter int MAX_RECORDS = DEF_MAX_RECORDS,
    parameter int CHUNK_SIZE  = DEF_CHUNK_SIZE,
    parameter int NAME_BYTES  = DEF_NAME_BYTES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [OP_W-1:0]             operation,
    input  logic signed [KEY_W-1:0]     record_key,
    input  logic [PAY_W-1:0]            record_payload,
    input  logic [IDX_IN_W-1:0]         entry_index,
    input  ckrt_cmd_t                   cmd,
    output ckrt_sts_t                   sts,
    output logic [ST_W-1:0]             status,
    output logic [CNT_OUT_W-1:0]        record_count,
    output logic [CNT_OUT_W-1:0]        table_capacity,
    output logic signed [KEY_W-1:0]     read_key,
    output logic [PAY_W-1:0]            read_payload
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int AW    = $clog2(MAX_RECORDS);
    localparam int SUM_W = $clog2(MAX_RECORDS + CHUNK_SIZE + 1);
    localparam int CMP_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
    localparam int REC_W = KEY_W + PAY_W;
    localparam logic [PAY_W-1:0] PAY_MASK = (NAME_BYTES >= 8) ? {PAY_W{1'b1}} :
        ((PAY_W'(1) << (8 * NAME_BYTES)) - PAY_W'(1));
    localparam logic [SUM_W-1:0] MAX_S   = SUM_W'(MAX_RECORDS);
    localparam logic [SUM_W-1:0] CHUNK_S = SUM_W'(CHUNK_SIZE);

    logic [OP_W-1:0]      op_reg, op_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [PAY_W-1:0]     pay_reg, pay_next;
    logic [IDX_IN_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     cap_reg, cap_next;
    logic [ST_W-1:0]      status_reg, status_next;
    logic [KEY_W-1:0]     rkey_reg, rkey_next;
    logic [PAY_W-1:0]     rpay_reg, rpay_next;
    logic [ST_W-1:0]      status_out_reg, status_out_next;
    logic [CNT_W-1:0]     count_out_reg, count_out_next;
    logic [CNT_W-1:0]     cap_out_reg, cap_out_next;
    logic [KEY_W-1:0]     rkey_out_reg, rkey_out_next;
    logic [PAY_W-1:0]     rpay_out_reg, rpay_out_next;

    logic [CNT_W:0]       ptr_p1;
    logic [CNT_W:0]       ptr_p2;
    logic [SUM_W-1:0]     count_w;
    logic [SUM_W-1:0]     cap_w;
    logic [CNT_W-1:0]     cnt_dec;
    logic                 add_grow;
    logic                 add_full;
    logic                 shrink;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [REC_W-1:0]     wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [REC_W-1:0]     rd_data;

    assign ptr_p1   = {1'b0, ptr_reg} + (CNT_W+1)'(1);
    assign ptr_p2   = {1'b0, ptr_reg} + (CNT_W+1)'(2);
    assign count_w  = SUM_W'(count_reg);
    assign cap_w    = SUM_W'(cap_reg);
    assign cnt_dec  = count_reg - CNT_W'(1);
    assign add_grow = (count_w >= cap_w);
    assign add_full = (count_w >= MAX_S) || (add_grow && (cap_w + CHUNK_S > MAX_S));
    assign shrink   = (cap_w >= CHUNK_S) && (SUM_W'(cnt_dec) <= cap_w - CHUNK_S);

    assign sts.op            = op_reg;
    assign sts.count_zero    = (count_reg == '0);
    assign sts.idx_ok        = (CMP_W'(idx_reg) < CMP_W'(count_reg));
    assign sts.key_match     = (rd_data[REC_W-1 -: KEY_W] == key_reg);
    assign sts.ptr_last      = (ptr_p1 >= {1'b0, count_reg});
    assign sts.ptr_next_last = (ptr_p2 >= {1'b0, count_reg});

    // record memory ports
    always_comb
    begin
        wr_en   = (cmd.add_exec && !add_full) || cmd.wr_shift;
        wr_addr = cmd.wr_shift ? ptr_reg[AW-1:0] : count_reg[AW-1:0];
        wr_data = cmd.wr_shift ? rd_data : {key_reg, pay_reg};
        rd_en   = (cmd.rd_sel != RD_NONE);
        case (cmd.rd_sel)
            RD_IDX:  rd_addr = AW'(idx_reg);
            RD_PTR:  rd_addr = ptr_reg[AW-1:0];
            RD_PTR1: rd_addr = ptr_p1[AW-1:0];
            RD_PTR2: rd_addr = ptr_p2[AW-1:0];
            default: rd_addr = '0;
        endcase
    end

    ckrt_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_ckrt_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        idx_next        = idx_reg;
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        cap_next        = cap_reg;
        status_next     = status_reg;
        rkey_next       = rkey_reg;
        rpay_next       = rpay_reg;
        status_out_next = status_out_reg;
        count_out_next  = count_out_reg;
        cap_out_next    = cap_out_reg;
        rkey_out_next   = rkey_out_reg;
        rpay_out_next   = rpay_out_reg;

        if (cmd.capture)
        begin
            op_next     = operation;
            key_next    = record_key;
            pay_next    = record_payload & PAY_MASK;
            idx_next    = entry_index;
            ptr_next    = '0;
            status_next = ST_OK;
            rkey_next   = '0;
            rpay_next   = '0;
        end
        if (cmd.add_exec)
        begin
            if (add_full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                if (add_grow)
                begin
                    cap_next = CNT_W'(cap_w + CHUNK_S);
                end
            end
        end
        if (cmd.read_take)
        begin
            rkey_next = rd_data[REC_W-1 -: KEY_W];
            rpay_next = rd_data[PAY_W-1:0];
        end
        if (cmd.ptr_inc)
        begin
            ptr_next = ptr_p1[CNT_W-1:0];
        end
        if (cmd.remove_commit)
        begin
            count_next = cnt_dec;
            if (shrink)
            begin
                cap_next = CNT_W'(cap_w - CHUNK_S);
            end
        end
        if (cmd.set_status)
        begin
            status_next = cmd.status_code;
        end
        if (cmd.load_out)
        begin
            status_out_next = status_reg;
            count_out_next  = count_reg;
            cap_out_next    = cap_reg;
            rkey_out_next   = rkey_reg;
            rpay_out_next   = rpay_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        pay_reg        <= pay_next;
        idx_reg        <= idx_next;
        ptr_reg        <= ptr_next;
        status_reg     <= status_next;
        rkey_reg       <= rkey_next;
        rpay_reg       <= rpay_next;
        status_out_reg <= status_out_next;
        count_out_reg  <= count_out_next;
        cap_out_reg    <= cap_out_next;
        rkey_out_reg   <= rkey_out_next;
        rpay_out_reg   <= rpay_out_next;
    end

    assign status         = status_out_reg;
    assign record_count   = CNT_OUT_W'(count_out_reg);
    assign table_capacity = CNT_OUT_W'(cap_out_reg);
    assign read_key       = rkey_out_reg;
    assign read_payload   = rpay_out_reg;

endmodule

@@ design/ckrt_controller.sv @@
// ----------------------------------------------------------------------------
// ckrt_controller
// sequencer for add, read, key search and left-shift compaction
// ----------------------------------------------------------------------------
module ckrt_controller
    import ckrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  ckrt_sts_t sts,
    output ckrt_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                case (sts.op)
                    OP_ADD:
                    begin
                        cmd.add_exec = 1'b1;
                    end
                    OP_REMOVE:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NOT_FOUND;
                        end
                        else
                        begin
                            cmd.rd_sel = RD_PTR;
                            state_next = S_SEARCH;
                        end
                    end
                    OP_READ:
                    begin
                        if (sts.idx_ok)
                        begin
                            cmd.rd_sel = RD_IDX;
                            state_next = S_READ;
                        end
                        else
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_BAD_INDEX;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_READ:
            begin
                cmd.read_take = 1'b1;
                state_next    = S_DONE;
            end
            S_SEARCH:
            begin
                if (sts.key_match)
                begin
                    if (sts.ptr_last)
                    begin
                        cmd.remove_commit = 1'b1;
                        state_next        = S_DONE;
                    end
                    else
                    begin
                        cmd.rd_sel = RD_PTR1;
                        state_next = S_SHIFT;
                    end
                end
                else if (sts.ptr_last)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    cmd.rd_sel  = RD_PTR1;
                end
            end
            S_SHIFT:
            begin
                cmd.wr_shift = 1'b1;
                if (sts.ptr_next_last)
                begin
                    cmd.remove_commit = 1'b1;
                    state_next        = S_DONE;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    cmd.rd_sel  = RD_PTR2;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/compacting_keyed_record_table_unit.sv @@
// ----------------------------------------------------------------------------
// compacting_keyed_record_table_unit
// contiguous key/payload table with chunked capacity and compacting remove
//
// input channel (in_valid/in_ready) takes one request: add, remove by key
// or read at index. output channel (out_valid/out_ready) returns one result
// per request: status, count, capacity and the record read.
// in_ready is high only while no request is in progress; a result waiting
// in the output register does not block the next request.
// add, unused codes, reads beyond the count and remove on an empty table
// go from dispatch straight to done; a read that returns a record passes
// through the read state first; remove walks the table one entry a cycle
// through the record memory's single read port.
// a stalled receiver holds the result; a finished request then waits
// until the output register frees before the next request is taken.
// reset empties the table: count and capacity go to zero, no result is
// pending, and memory contents are left as they are.
// ----------------------------------------------------------------------------
module compacting_keyed_record_table_unit
    import ckrt_pkg::*;
#(
    parameter int MAX_RECORDS = DEF_MAX_RECORDS,
    parameter int CHUNK_SIZE  = DEF_CHUNK_SIZE,
    parameter int NAME_BYTES  = DEF_NAME_BYTES
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [OP_W-1:0]         operation,
    input  logic signed [KEY_W-1:0] record_key,
    input  logic [PAY_W-1:0]        record_payload,
    input  logic [IDX_IN_W-1:0]     entry_index,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ST_W-1:0]         status,
    output logic [CNT_OUT_W-1:0]    record_count,
    output logic [CNT_OUT_W-1:0]    table_capacity,
    output logic signed [KEY_W-1:0] read_key,
    output logic [PAY_W-1:0]        read_payload
);

    ckrt_cmd_t cmd;
    ckrt_sts_t sts;

    ckrt_controller u_ckrt_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ckrt_datapath #(
        .MAX_RECORDS (MAX_RECORDS),
        .CHUNK_SIZE  (CHUNK_SIZE),
        .NAME_BYTES  (NAME_BYTES)
    ) u_ckrt_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .operation      (operation),
        .record_key     (record_key),
        .record_payload (record_payload),
        .entry_index    (entry_index),
        .cmd            (cmd),
        .sts            (sts),
        .status         (status),
        .record_count   (record_count),
        .table_capacity (table_capacity),
        .read_key       (read_key),
        .read_payload   (read_payload)
    );

endmodule

@@ design/ckrt_checker.sv @@
// ----------------------------------------------------------------------------
// ckrt_checker
// port-level checks on the record table, bound to the top level
// ----------------------------------------------------------------------------
`include "compacting_keyed_record_table_unit_defines.svh"

module ckrt_checker
    import ckrt_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [ST_W-1:0]         status,
    input logic [CNT_OUT_W-1:0]    record_count,
    input logic [CNT_OUT_W-1:0]    table_capacity,
    input logic signed [KEY_W-1:0] read_key,
    input logic [PAY_W-1:0]        read_payload
);

    `CKRT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(record_count) && $stable(read_payload), "result changed while stalled")
    `CKRT_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "request taken while one is in progress")
    `CKRT_ASSERT_NOW(a_count_in_cap, clk, rst_n, out_valid, record_count <= table_capacity, "count above capacity")
    `CKRT_ASSERT_NOW(a_full_at_cap, clk, rst_n, out_valid && status == ST_FULL, record_count == table_capacity, "full reported below capacity")
    `CKRT_ASSERT_NOW(a_read_zero, clk, rst_n, out_valid && status != ST_OK, read_key == '0 && read_payload == '0, "read fields set on failed request")

endmodule

bind compacting_keyed_record_table_unit ckrt_checker u_ckrt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .record_count   (record_count),
    .table_capacity (table_capacity),
    .read_key       (read_key),
    .read_payload   (read_payload)
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for compacting_keyed_record_table_unit
// a table of directed requests (empty table, key and payload extremes,
// growth to full, duplicate keys, bad index, unused code) then random
// add/remove/read/unused traffic; results are checked against row values or
// a table model under random sender and receiver idling and one long receiver hold-off
// ----------------------------------------------------------------------------
module testbench;
    import ckrt_pkg::*;

    localparam int MAXR = DEF_MAX_RECORDS;
    localparam int CHUNK = DEF_CHUNK_SIZE;
    localparam logic [PAY_W-1:0] PAY_MASK = (DEF_NAME_BYTES >= 8) ? {PAY_W{1'b1}} :
        ((64'd1 << (8 * DEF_NAME_BYTES)) - 64'd1);
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1625;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 50;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic [CNT_OUT_W-1:0]    rec_count;
        logic [CNT_OUT_W-1:0]    capacity;
        logic signed [KEY_W-1:0] rd_key;
        logic [PAY_W-1:0]        rd_payload;
    } table_result_t;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        pay;
        logic [IDX_IN_W-1:0]     idx;
        logic                    typed;
        table_result_t           want;
    } directed_row_t;

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [OP_W-1:0]         operation = '0;
    logic signed [KEY_W-1:0] record_key = '0;
    logic [PAY_W-1:0]        record_payload = '0;
    logic [IDX_IN_W-1:0]     entry_index = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [ST_W-1:0]         status;
    logic [CNT_OUT_W-1:0]    record_count;
    logic [CNT_OUT_W-1:0]    table_capacity;
    logic signed [KEY_W-1:0] read_key;
    logic [PAY_W-1:0]        read_payload;

    logic signed [KEY_W-1:0] table_keys [MAXR];
    logic [PAY_W-1:0]        table_pays [MAXR];
    int                      held = 0;
    int                      cap_level = 0;

    table_result_t           pending_results [$];
    directed_row_t           directed_rows [$];
    int                      mismatch_count = 0;
    int                      cycle_count = 0;
    int                      send_idle_pct = 9;
    int                      recv_idle_pct = 62;
    bit                      hold_trigger = 1'b0;

    compacting_keyed_record_table_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .record_key     (record_key),
        .record_payload (record_payload),
        .entry_index    (entry_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .record_count   (record_count),
        .table_capacity (table_capacity),
        .read_key       (read_key),
        .read_payload   (read_payload)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic table_result_t apply_request(input logic [OP_W-1:0] op,
                                                    input logic signed [KEY_W-1:0] key,
                                                    input logic [PAY_W-1:0] pay,
                                                    input logic [IDX_IN_W-1:0] idx);
        table_result_t res;
        int pos;
        res = '0;
        res.status = ST_OK;
        case (op)
            OP_ADD:
            begin
                if (held >= MAXR || (held >= cap_level && cap_level + CHUNK > MAXR))
                    res.status = ST_FULL;
                else
                begin
                    if (held >= cap_level)
                        cap_level += CHUNK;
                    table_keys[held] = key;
                    table_pays[held] = pay & PAY_MASK;
                    held++;
                end
            end
            OP_REMOVE:
            begin
                pos = 0;
                while (pos < held && table_keys[pos] != key)
                    pos++;
                if (pos >= held)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    for (int j = pos; j + 1 < held; j++)
                    begin
                        table_keys[j] = table_keys[j + 1];
                        table_pays[j] = table_pays[j + 1];
                    end
                    held--;
                    if (cap_level >= CHUNK && held <= cap_level - CHUNK)
                        cap_level -= CHUNK;
                end
            end
            OP_READ:
            begin
                if (idx < held)
                begin
                    res.rd_key = table_keys[idx];
                    res.rd_payload = table_pays[idx];
                end
                else
                    res.status = ST_BAD_INDEX;
            end
            default:
            begin
            end
        endcase
        res.rec_count = CNT_OUT_W'(held);
        res.capacity = CNT_OUT_W'(cap_level);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [PAY_W-1:0] got,
                                   input logic [PAY_W-1:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    task automatic plan_row(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key,
                            input logic [PAY_W-1:0] pay, input logic [IDX_IN_W-1:0] idx,
                            input logic typed, input logic [ST_W-1:0] st,
                            input logic [CNT_OUT_W-1:0] cnt, input logic [CNT_OUT_W-1:0] cap,
                            input logic signed [KEY_W-1:0] rk, input logic [PAY_W-1:0] rp);
        directed_row_t row;
        row.op = op;
        row.key = key;
        row.pay = pay;
        row.idx = idx;
        row.typed = typed;
        row.want.status = st;
        row.want.rec_count = cnt;
        row.want.capacity = cap;
        row.want.rd_key = rk;
        row.want.rd_payload = rp;
        directed_rows.push_back(row);
    endtask

    task automatic send_request(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key,
                                input logic [PAY_W-1:0] pay, input logic [IDX_IN_W-1:0] idx,
                                input logic typed, input table_result_t want);
        int gap;
        table_result_t predicted;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        record_key <= key;
        record_payload <= pay;
        entry_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = apply_request(op, key, pay, idx);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // result side: random ready, long hold-off on request
    initial
    begin
        table_result_t want;
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with no pending request", '0, '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (record_count !== want.rec_count)
                        report_mismatch("record_count", record_count, want.rec_count);
                    if (table_capacity !== want.capacity)
                        report_mismatch("table_capacity", table_capacity, want.capacity);
                    if (read_key !== want.rd_key)
                        report_mismatch("read_key", read_key, want.rd_key);
                    if (read_payload !== want.rd_payload)
                        report_mismatch("read_payload", read_payload, want.rd_payload);
                end
            end
            if (hold_trigger)
            begin
                hold_trigger = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
                hold_left--;
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [OP_W-1:0]         op;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        pay;
        logic [IDX_IN_W-1:0]     idx;
        int                      counted;
        int                      roll;
        bit                      add_heavy;

        plan_row(OP_READ, 32'sd0, 64'd0, 4'd0, 1'b1, ST_BAD_INDEX, 5'd0, 5'd0, 32'sd0, 64'd0);
        plan_row(OP_REMOVE, 32'sd0, 64'd0, 4'd0, 1'b1, ST_NOT_FOUND, 5'd0, 5'd0, 32'sd0, 64'd0);
        plan_row(OP_UNUSED, 32'h5a5a5a5a, {PAY_W{1'b1}}, 4'd15, 1'b1,
                 ST_OK, 5'd0, 5'd0, 32'sd0, 64'd0);
        plan_row(OP_ADD, 32'h80000000, {PAY_W{1'b1}}, 4'd0, 1'b1,
                 ST_OK, 5'd1, 5'd4, 32'sd0, 64'd0);
        plan_row(OP_ADD, 32'h7fffffff, 64'd0, 4'd15, 1'b1, ST_OK, 5'd2, 5'd4, 32'sd0, 64'd0);
        plan_row(OP_READ, 32'sd0, 64'd0, 4'd0, 1'b1,
                 ST_OK, 5'd2, 5'd4, 32'h80000000, {PAY_W{1'b1}});
        plan_row(OP_READ, 32'sd0, 64'd0, 4'd1, 1'b1, ST_OK, 5'd2, 5'd4, 32'h7fffffff, 64'd0);
        plan_row(OP_READ, 32'sd0, 64'd0, 4'd15, 1'b1, ST_BAD_INDEX, 5'd2, 5'd4, 32'sd0, 64'd0);
        plan_row(OP_READ, 32'sd0, 64'd0, 4'd2, 1'b1, ST_BAD_INDEX, 5'd2, 5'd4, 32'sd0, 64'd0);
        plan_row(OP_ADD, 32'sd5, 64'h0123456789abcdef, 4'd0, 1'b0, '0, '0, '0, '0, '0);
        plan_row(OP_ADD, 32'sd5, 64'hfedcba9876543210, 4'd0, 1'b0, '0, '0, '0, '0, '0);
        plan_row(OP_ADD, -32'sd1, 64'h8000000000000001, 4'd0, 1'b0, '0, '0, '0, '0, '0);
        for (int i = 0; i < 11; i++)
            plan_row(OP_ADD, 32'sd100 + i, {$urandom, $urandom}, IDX_IN_W'(i), 1'b0,
                     '0, '0, '0, '0, '0);
        plan_row(OP_ADD, 32'sd7, 64'd7, 4'd0, 1'b1, ST_FULL, 5'd16, 5'd16, 32'sd0, 64'd0);
        plan_row(OP_REMOVE, 32'sd5, 64'd0, 4'd0, 1'b0, '0, '0, '0, '0, '0);
        plan_row(OP_READ, 32'sd0, 64'd0, 4'd2, 1'b0, '0, '0, '0, '0, '0);
        plan_row(OP_REMOVE, 32'h7fffffff, 64'd0, 4'd0, 1'b0, '0, '0, '0, '0, '0);
        plan_row(OP_REMOVE, 32'h12345678, 64'd0, 4'd0, 1'b1,
                 ST_NOT_FOUND, 5'd14, 5'd16, 32'sd0, 64'd0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].pay,
                         directed_rows[i].idx, directed_rows[i].typed, directed_rows[i].want);

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted == 550)
            begin
                send_idle_pct = 62;
                recv_idle_pct = 9;
            end
            if (counted == 1100)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (counted == 1300)
                hold_trigger = 1'b1;

            // alternate growing and shrinking stretches so the count sweeps the range
            add_heavy = ((counted / 40) % 2) == 0;
            roll = $urandom_range(99);
            if (roll < (add_heavy ? 55 : 20))
                op = OP_ADD;
            else if (roll < (add_heavy ? 75 : 72))
                op = OP_REMOVE;
            else if (roll < 97)
                op = OP_READ;
            else
                op = OP_UNUSED;

            roll = $urandom_range(99);
            if (op == OP_REMOVE && held > 0 && roll < 65)
                key = table_keys[$urandom_range(held - 1)];
            else if (roll < 85)
            begin
                case ($urandom_range(7))
                    0: key = 32'sd0;
                    1: key = 32'sd1;
                    2: key = -32'sd1;
                    3: key = 32'h7fffffff;
                    4: key = 32'h80000000;
                    5: key = 32'sd42;
                    6: key = -32'sd42;
                    default: key = 32'sd1000;
                endcase
            end
            else
                key = $urandom;

            pay = {$urandom, $urandom};
            if (held > 0 && $urandom_range(3) != 0)
                idx = IDX_IN_W'($urandom_range(held - 1));
            else
                idx = IDX_IN_W'($urandom_range(15));

            send_request(op, key, pay, idx, 1'b0, '0);
            counted++;
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
